FILE: src/aes256_block_cipher_unit_defines.svh
// Assertion macros used by the checker file.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef AES256_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define AES256_BLOCK_CIPHER_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define AES256_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aes256 check failed");

// Consequent holds in the cycle after the antecedent
`define AES256_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aes256 check failed");

`endif

FILE: src/aes256_pkg.sv
`default_nettype none
package aes256_pkg;

    typedef logic [127:0] t_block;

    localparam int     NUM_ROWS = 15;
    localparam int     ROW_AW   = 4;
    localparam logic [ROW_AW-1:0] LAST_ROW = 4'd14;
    localparam logic [7:0] RC_INIT  = 8'h01;
    localparam logic [7:0] POLY_LOW = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_REV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ POLY_LOW) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte n of the block sits at bits 127-8n
    function automatic t_block sub_bytes(input t_block s, input logic inv);
        t_block o;
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = inv ? SBOX_REV[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        end
        return o;
    endfunction

    function automatic t_block shift_rows(input t_block s, input logic inv);
        t_block o;
        int     src;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*src) -: 8];
            end
        end
        return o;
    endfunction

    function automatic t_block mix_columns(input t_block s, input logic inv);
        t_block     o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = s[127-8*(k+4*c) -: 8];
                x2[k] = xtime(a[k]);
                x4[k] = xtime(x2[k]);
                x8[k] = xtime(x4[k]);
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    // rows of {0e, 0b, 0d, 09}
                    o[127-8*(r+4*c) -: 8] =
                        (x8[r] ^ x4[r] ^ x2[r]) ^
                        (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3]) ^
                        (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3]) ^
                        (x8[(r+3)&3] ^ a[(r+3)&3]);
                end else begin
                    // rows of {02, 03, 01, 01}
                    o[127-8*(r+4*c) -: 8] = x2[r] ^ x2[(r+1)&3] ^ a[(r+1)&3] ^
                                            a[(r+2)&3] ^ a[(r+3)&3];
                end
            end
        end
        return o;
    endfunction

    function automatic t_block enc_round(input t_block s, input t_block k, input logic last);
        t_block t;
        t = shift_rows(sub_bytes(s, 1'b0), 1'b0);
        if (!last) begin
            t = mix_columns(t, 1'b0);
        end
        return t ^ k;
    endfunction

    function automatic t_block dec_round(input t_block s, input t_block k, input logic last);
        t_block t;
        t = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ k;
        if (!last) begin
            t = mix_columns(t, 1'b1);
        end
        return t;
    endfunction

    // Next four schedule words from the last eight; rot selects the RotWord+Rcon step
    function automatic t_block key_step(input logic [255:0] win, input logic [7:0] rc,
                                        input logic rot);
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        t  = rot ? (sub_word({win[23:0], win[31:24]}) ^ {rc, 24'h0}) : sub_word(win[31:0]);
        n0 = win[255:224] ^ t;
        n1 = win[223:192] ^ n0;
        n2 = win[191:160] ^ n1;
        n3 = win[159:128] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage
`default_nettype wire

FILE: src/aes256_ram.sv
`default_nettype none
module aes256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/aes256_block_cipher_unit.sv
`default_nettype none
// AES-256 single-block cipher, encrypt or inverse cipher, 14 rounds.
// Key: four 64-bit registers on the APB port at byte offsets 0, 8, 16, 24
// (key bytes 0..7 first). Write the key only while the unit is idle.
// Blocks: a command is taken when start is high and busy is low; i_req_type
// picks encrypt (0) or decrypt (1). The result appears on o_result_high/low
// for one cycle with o_valid; the receiver cannot stall it.
// With a current key schedule, a taken block first reads the first round key,
// then runs one round per cycle for the initial key addition and 14 rounds;
// o_valid and the result are registered from the last round. busy drops in
// the cycle the result shows, so a new block is taken only after the last one.
// After reset or any key write, the next block first rebuilds the schedule,
// one 128-bit round-key row written per cycle.
// The round keys sit in a 15 x 128 memory with one read and one write port;
// the single round unit and that read port set the rate.
// Reset clears the key registers to zero and marks the schedule stale.
module aes256_block_cipher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    output logic             o_valid,
    output logic      [63:0] o_result_high,
    output logic      [63:0] o_result_low,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXPAND = 4'b0010,
        S_LOAD   = 4'b0100,
        S_ROUND  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [63:0] r_key [4];
    logic        r_ready, n_ready;
    logic        r_dec, n_dec;
    logic [aes256_pkg::ROW_AW-1:0] r_cnt, n_cnt;
    logic [7:0]   r_rc, n_rc;
    logic [255:0] r_win, n_win;
    aes256_pkg::t_block r_blk, n_blk;
    logic         r_valid, n_valid;
    logic [127:0] r_res, n_res;

    logic         cfg_wr;
    logic         we;
    logic [aes256_pkg::ROW_AW-1:0] raddr;
    aes256_pkg::t_block wdata;
    aes256_pkg::t_block rkey;
    logic         last;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = r_key[paddr[4:3]];
    assign busy   = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_result_high = r_res[127:64];
    assign o_result_low  = r_res[63:0];
    assign last = (r_cnt == aes256_pkg::LAST_ROW);

    // round-key memory, one row per round
    aes256_ram #(
        .WIDTH (128),
        .DEPTH (aes256_pkg::NUM_ROWS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rkey)
    );

    // schedule rows: key halves first, then four words per step
    always_comb begin
        if (r_cnt == '0) begin
            wdata = r_win[255:128];
        end else if (r_cnt == 4'd1) begin
            wdata = r_win[127:0];
        end else begin
            wdata = aes256_pkg::key_step(r_win, r_rc, ~r_cnt[0]);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        n_dec   = r_dec;
        n_cnt   = r_cnt;
        n_rc    = r_rc;
        n_win   = r_win;
        n_blk   = r_blk;
        n_valid = 1'b0;
        n_res   = r_res;
        we      = 1'b0;
        raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_dec = i_req_type;
                    n_blk = {i_block_high, i_block_low};
                    n_cnt = '0;
                    n_rc  = aes256_pkg::RC_INIT;
                    n_win = {r_key[0], r_key[1], r_key[2], r_key[3]};
                    n_state = r_ready ? S_LOAD : S_EXPAND;
                end
            end
            S_EXPAND: begin
                we = 1'b1;
                if (r_cnt >= 4'd2) begin
                    n_win = {r_win[127:0], wdata};
                    if (!r_cnt[0]) begin
                        n_rc = aes256_pkg::xtime(r_rc);
                    end
                end
                if (last) begin
                    n_ready = 1'b1;
                    n_cnt   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_LOAD: begin
                raddr   = r_dec ? aes256_pkg::LAST_ROW : '0;
                n_cnt   = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // fetch the next row in the cycle before its round uses it
                if (!last) begin
                    raddr = r_dec ? (aes256_pkg::LAST_ROW - r_cnt - 4'd1) : (r_cnt + 4'd1);
                end
                if (r_cnt == '0) begin
                    n_blk = r_blk ^ rkey;
                end else if (r_dec) begin
                    n_blk = aes256_pkg::dec_round(r_blk, rkey, last);
                end else begin
                    n_blk = aes256_pkg::enc_round(r_blk, rkey, last);
                end
                if (last) begin
                    n_res   = n_blk;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // any key write makes the schedule stale
        if (cfg_wr) begin
            n_ready = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
            r_valid <= 1'b0;
            r_key   <= '{default: 64'h0};
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_valid <= n_valid;
            if (cfg_wr) begin
                r_key[paddr[4:3]] <= pwdata;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
        r_cnt <= n_cnt;
        r_rc  <= n_rc;
        r_win <= n_win;
        r_blk <= n_blk;
        r_res <= n_res;
    end

endmodule
`default_nettype wire

FILE: src/aes256_chk.sv
`default_nettype none
`include "aes256_block_cipher_unit_defines.svh"
module aes256_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid
);

    // a taken command occupies the unit
    `AES256_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // no result the cycle right after a command beat
    `AES256_ASSERT_NEXT(a_no_early_result, start && !busy, !o_valid)
    // the result beat finds the unit free again
    `AES256_ASSERT_SAME(a_result_idle, o_valid, !busy)
    // one beat per block
    `AES256_ASSERT_NEXT(a_single_beat, o_valid, !o_valid)

endmodule

bind aes256_block_cipher_unit aes256_chk u_chk (.*);
`default_nettype wire
